// ===== rtl/cvfq_pkg.sv =====
package cvfq_pkg;

  localparam int NumCells = 30;
  localparam int CellIdxW = (NumCells > 1) ? $clog2(NumCells) : 1;

  localparam int CellW   = 5;
  localparam int VoltW   = 16;
  localparam int CountW  = 8;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StOver    = 2'd1;
  localparam logic [StatusW-1:0] StUnder   = 2'd2;
  localparam logic [StatusW-1:0] StIgnored = 2'd3;

  localparam logic [CfgIdxW-1:0] RegOverLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUnderLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBadLimit   = 2'd2;

  localparam logic [VoltW-1:0]  OverLimitReset  = 16'd42000;
  localparam logic [VoltW-1:0]  UnderLimitReset = 16'd27500;
  localparam logic [CountW-1:0] BadLimitReset   = 8'd30;

endpackage

// ===== rtl/cvfq_if.sv =====
interface cvfq_sample_if;
  logic                         valid;
  logic                         ready;
  logic [cvfq_pkg::CellW-1:0]   cell_index;
  logic [cvfq_pkg::VoltW-1:0]   cell_voltage;
  logic                         scan_last;

  modport source (output valid, output cell_index, output cell_voltage, output scan_last,
                  input ready);
  modport sink (input valid, input cell_index, input cell_voltage, input scan_last,
                output ready);
endinterface

interface cvfq_result_if;
  logic                         valid;
  logic                         ready;
  logic [cvfq_pkg::StatusW-1:0] fault_status;
  logic [cvfq_pkg::CellW-1:0]   fault_cell;
  logic                         scan_safe;

  modport source (output valid, output fault_status, output fault_cell, output scan_safe,
                  input ready);
  modport sink (input valid, input fault_status, input fault_cell, input scan_safe,
                output ready);
endinterface

// ===== rtl/cell_voltage_fault_qualifier_unit.sv =====
// Cell voltage fault qualifier.
// samples: one transaction per cell voltage sample (cell_index, cell_voltage,
//   scan_last). results: exactly one transaction per sample, in order, with
//   fault_status (ok / over trip / under trip / ignored), fault_cell and scan_safe.
// cfg_we/cfg_index/cfg_data write the over limit (0), under limit (1) and
//   bad-sample limit (2); write only while no sample is in flight.
// A sample passes through the input register, then one pass of compare and
//   count update into the result register. Throughput: one sample per cycle
//   while results.ready stays high; the per-cell counters are read and written
//   in that single stage, so back-to-back samples of the same cell need no
//   forwarding.
// When results.ready is low the result register holds; one more sample can
//   be held in the input register, after which samples.ready drops.
// Reset clears all counts, the trip latch and both pipeline stages, and loads
//   the default limits. A trip stays latched until reset; later samples
//   report ignored and leave the counts alone.
module cell_voltage_fault_qualifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  cvfq_sample_if.sink                   samples,
  cvfq_result_if.source                 results,
  input  logic                          cfg_we,
  input  logic [cvfq_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cvfq_pkg::CfgW-1:0]     cfg_data
);

  logic [cvfq_pkg::VoltW-1:0]  over_limit;
  logic [cvfq_pkg::VoltW-1:0]  under_limit;
  logic [cvfq_pkg::CountW-1:0] bad_limit;

  logic [cvfq_pkg::CountW-1:0] over_counts  [cvfq_pkg::NumCells];
  logic [cvfq_pkg::CountW-1:0] under_counts [cvfq_pkg::NumCells];
  logic                        trip_latched;

  logic                        stage_valid;
  logic [cvfq_pkg::CellW-1:0]  stage_cell;
  logic [cvfq_pkg::VoltW-1:0]  stage_volt;
  logic                        stage_last;

  logic                          res_valid;
  logic [cvfq_pkg::StatusW-1:0]  res_status;
  logic [cvfq_pkg::CellW-1:0]    res_cell;
  logic                          res_safe;

  logic                          advance;
  logic                          accept;
  logic [cvfq_pkg::CellIdxW-1:0] idx;
  logic                          in_range;
  logic                          is_over;
  logic                          is_under;
  logic [cvfq_pkg::CountW-1:0]   over_cur;
  logic [cvfq_pkg::CountW-1:0]   under_cur;
  logic [cvfq_pkg::CountW-1:0]   over_next;
  logic [cvfq_pkg::CountW-1:0]   under_next;
  logic                          trip_over;
  logic                          trip_under;
  logic                          update;
  logic [cvfq_pkg::StatusW-1:0]  res_status_next;
  logic [cvfq_pkg::CellW-1:0]    res_cell_next;
  logic                          res_safe_next;

  assign advance       = stage_valid && (!res_valid || results.ready);
  assign samples.ready = !stage_valid || !res_valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  assign results.valid        = res_valid;
  assign results.fault_status = res_status;
  assign results.fault_cell   = res_cell;
  assign results.scan_safe    = res_safe;

  always_ff @(posedge clk) begin
    if (rst) begin
      over_limit  <= cvfq_pkg::OverLimitReset;
      under_limit <= cvfq_pkg::UnderLimitReset;
      bad_limit   <= cvfq_pkg::BadLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvfq_pkg::RegOverLimit:  over_limit  <= cfg_data;
        cvfq_pkg::RegUnderLimit: under_limit <= cfg_data;
        cvfq_pkg::RegBadLimit:   bad_limit   <= cfg_data[cvfq_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign idx      = cvfq_pkg::CellIdxW'(stage_cell);
  assign in_range = 32'(stage_cell) < cvfq_pkg::NumCells;
  assign over_cur  = in_range ? over_counts[idx]  : '0;
  assign under_cur = in_range ? under_counts[idx] : '0;

  assign is_over  = stage_volt >= over_limit;
  assign is_under = !is_over && (stage_volt <= under_limit);

  always_comb begin
    if (is_over) begin
      over_next  = (over_cur == cvfq_pkg::CountMax) ? over_cur : over_cur + 1'b1;
      under_next = under_cur;
    end else if (is_under) begin
      over_next  = over_cur;
      under_next = (under_cur == cvfq_pkg::CountMax) ? under_cur : under_cur + 1'b1;
    end else begin
      over_next  = '0;
      under_next = '0;
    end
  end

  assign trip_over  = over_next >= bad_limit;
  assign trip_under = under_next >= bad_limit;
  assign update     = advance && !trip_latched && in_range;

  always_comb begin
    res_status_next = cvfq_pkg::StOk;
    res_cell_next   = '0;
    res_safe_next   = 1'b0;
    if (trip_latched) begin
      res_status_next = cvfq_pkg::StIgnored;
    end else if (!in_range) begin
      res_safe_next = stage_last;
    end else if (trip_over) begin
      res_status_next = cvfq_pkg::StOver;
      res_cell_next   = stage_cell;
    end else if (trip_under) begin
      res_status_next = cvfq_pkg::StUnder;
      res_cell_next   = stage_cell;
    end else begin
      res_safe_next = stage_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cvfq_pkg::NumCells; i++) begin
        over_counts[i]  <= '0;
        under_counts[i] <= '0;
      end
      trip_latched <= 1'b0;
    end else if (update) begin
      over_counts[idx]  <= over_next;
      under_counts[idx] <= under_next;
      if (trip_over || trip_under) begin
        trip_latched <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cell <= samples.cell_index;
      stage_volt <= samples.cell_voltage;
      stage_last <= samples.scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status <= res_status_next;
      res_cell   <= res_cell_next;
      res_safe   <= res_safe_next;
    end
  end

  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    trip_latched |=> trip_latched)
    else $error("trip latch cleared without reset");

  a_trip_result_latched: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == cvfq_pkg::StOver || res_status == cvfq_pkg::StUnder)
    |-> trip_latched)
    else $error("trip reported without latched trip");

  a_safe_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_safe |-> res_status == cvfq_pkg::StOk)
    else $error("scan_safe on non-ok result");

  a_cell_only_on_trip: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != cvfq_pkg::StOver && res_status != cvfq_pkg::StUnder
    |-> res_cell == '0)
    else $error("fault_cell set without trip");

endmodule

// ===== tb/sv/tb_cell_voltage_fault_qualifier_unit.sv =====
`timescale 1ns / 100ps

module tb_cell_voltage_fault_qualifier_unit;

  localparam int VoltMax    = (1 << cvfq_pkg::VoltW) - 1;
  localparam int CellMax    = (1 << cvfq_pkg::CellW) - 1;
  localparam int QuietLimit = 2000;
  localparam int IdleSwap   = 470;
  localparam int IdleOff    = 940;

  typedef struct packed {
    logic [cvfq_pkg::CellW-1:0] cell_id;
    logic [cvfq_pkg::VoltW-1:0] volt;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic [cvfq_pkg::StatusW-1:0] status;
    logic [cvfq_pkg::CellW-1:0]   cell_id;
    logic                         safe;
  } verdict_t;

  typedef struct packed {
    logic [cvfq_pkg::NumCells-1:0][cvfq_pkg::CountW-1:0] over_cnt;
    logic [cvfq_pkg::NumCells-1:0][cvfq_pkg::CountW-1:0] under_cnt;
    logic                                                tripped;
    logic [cvfq_pkg::VoltW-1:0]                          over_lim;
    logic [cvfq_pkg::VoltW-1:0]                          under_lim;
    logic [cvfq_pkg::CountW-1:0]                         bad_lim;
  } pack_state_t;

  typedef enum logic [1:0] {BAND_HIGH, BAND_LOW, BAND_MID} band_e;
  typedef enum logic [1:0] {
    TRIP_OVER_RUN, TRIP_UNDER_RUN, TRIP_ZERO_LIMIT, TRIP_BOTH_HIGH
  } trip_plan_e;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [cvfq_pkg::CfgIdxW-1:0] cfg_index;
  logic [cvfq_pkg::CfgW-1:0] cfg_data;

  cvfq_sample_if samples_if ();
  cvfq_result_if results_if ();

  cell_voltage_fault_qualifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pack follows accepted transactions; plan runs ahead with the queued ones
  pack_state_t pack;
  pack_state_t plan;
  sample_t     pending_q[$];
  verdict_t    expected_q[$];
  sample_t     on_wire;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_cfg_writes = 0;
  int n_over_trips = 0;
  int n_under_trips = 0;
  int n_ignored = 0;
  int n_safe = 0;
  int quiet_cycles = 0;

  function automatic verdict_t qualify_sample(inout pack_state_t st, input sample_t s);
    verdict_t v;
    v = '0;
    v.status = cvfq_pkg::StOk;
    if (st.tripped) begin
      v.status = cvfq_pkg::StIgnored;
    end else if (int'(s.cell_id) >= cvfq_pkg::NumCells) begin
      v.safe = s.last;
    end else begin
      if (s.volt >= st.over_lim) begin
        if (st.over_cnt[s.cell_id] != cvfq_pkg::CountMax)
          st.over_cnt[s.cell_id] = st.over_cnt[s.cell_id] + 8'd1;
      end else if (s.volt <= st.under_lim) begin
        if (st.under_cnt[s.cell_id] != cvfq_pkg::CountMax)
          st.under_cnt[s.cell_id] = st.under_cnt[s.cell_id] + 8'd1;
      end else begin
        st.over_cnt[s.cell_id] = '0;
        st.under_cnt[s.cell_id] = '0;
      end
      if (st.over_cnt[s.cell_id] >= st.bad_lim) begin
        st.tripped = 1'b1;
        v.status = cvfq_pkg::StOver;
        v.cell_id = s.cell_id;
      end else if (st.under_cnt[s.cell_id] >= st.bad_lim) begin
        st.tripped = 1'b1;
        v.status = cvfq_pkg::StUnder;
        v.cell_id = s.cell_id;
      end else begin
        v.safe = s.last;
      end
    end
    return v;
  endfunction

  function automatic void apply_reg(inout pack_state_t st,
                                    input logic [cvfq_pkg::CfgIdxW-1:0] idx,
                                    input int data);
    case (idx)
      cvfq_pkg::RegOverLimit:  st.over_lim = data[cvfq_pkg::VoltW-1:0];
      cvfq_pkg::RegUnderLimit: st.under_lim = data[cvfq_pkg::VoltW-1:0];
      cvfq_pkg::RegBadLimit:   st.bad_lim = data[cvfq_pkg::CountW-1:0];
      default: ;
    endcase
  endfunction

  function automatic sample_t make_sample(int cell_id, int volt, bit last);
    sample_t s;
    s.cell_id = cell_id[cvfq_pkg::CellW-1:0];
    s.volt = volt[cvfq_pkg::VoltW-1:0];
    s.last = last;
    return s;
  endfunction

  function automatic bit has_mid();
    return int'(plan.over_lim) >= int'(plan.under_lim) + 2;
  endfunction

  function automatic bit would_trip(int cell_id, int volt, bit last);
    pack_state_t scratch;
    verdict_t v;
    scratch = plan;
    v = qualify_sample(scratch, make_sample(cell_id, volt, last));
    return (v.status == cvfq_pkg::StOver) || (v.status == cvfq_pkg::StUnder);
  endfunction

  function automatic int draw_voltage(band_e band);
    int lo;
    int hi;
    lo = int'(plan.over_lim);
    hi = VoltMax;
    if (band == BAND_LOW && plan.over_lim != 0) begin
      lo = 0;
      hi = (plan.under_lim < plan.over_lim) ? int'(plan.under_lim) : int'(plan.over_lim) - 1;
    end else if (band == BAND_MID && has_mid()) begin
      lo = int'(plan.under_lim) + 1;
      hi = int'(plan.over_lim) - 1;
    end
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic band_e random_band(int p_high, int p_low);
    int r;
    r = $urandom_range(99);
    if (r < p_high) return BAND_HIGH;
    if (r < p_high + p_low) return BAND_LOW;
    return BAND_MID;
  endfunction

  function automatic void queue_reading(int cell_id, int volt, bit last);
    sample_t s;
    s = make_sample(cell_id, volt, last);
    void'(qualify_sample(plan, s));
    pending_q.push_back(s);
    n_queued++;
  endfunction

  // keeps the latch clear: a sample that would trip becomes an in-band one,
  // or a dropped cell when no in-band voltage exists or it would trip too
  function automatic void queue_steered(int cell_id, band_e band, bit last);
    int c;
    int volt;
    c = cell_id;
    volt = draw_voltage(band);
    if (would_trip(c, volt, last) && has_mid()) volt = draw_voltage(BAND_MID);
    if (would_trip(c, volt, last)) c = $urandom_range(CellMax, cvfq_pkg::NumCells);
    queue_reading(c, volt, last);
  endfunction

  function automatic void run_scans(int n_scans, int p_high, int p_low, int noise_pct);
    for (int n = 0; n < n_scans; n++) begin
      for (int c = 0; c < cvfq_pkg::NumCells; c++) begin
        if ($urandom_range(99) < noise_pct)
          queue_steered($urandom_range(CellMax), random_band(p_high, p_low),
                        1'($urandom_range(1)));
        queue_steered(c, random_band(p_high, p_low), c == cvfq_pkg::NumCells - 1);
      end
    end
  endfunction

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endfunction

  task automatic settle();
    while (n_results != n_queued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [cvfq_pkg::CfgIdxW-1:0] idx, int data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[cvfq_pkg::CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(pack, idx, data);
    apply_reg(plan, idx, data);
    n_cfg_writes++;
  endtask

  task automatic set_limits(int over_lim, int under_lim, int bad_lim);
    settle();
    write_reg(cvfq_pkg::RegOverLimit, over_lim);
    write_reg(cvfq_pkg::RegUnderLimit, under_lim);
    write_reg(cvfq_pkg::RegBadLimit, bad_lim);
  endtask

  always @(posedge clk) begin : drive_samples
    int idle_pct;
    idle_pct = (n_accepted < IdleSwap) ? 37 : (n_accepted < IdleOff) ? 50 : 0;
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        expected_q.push_back(qualify_sample(pack, on_wire));
        n_accepted++;
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_wire = pending_q.pop_front();
          samples_if.valid <= 1'b1;
          samples_if.cell_index <= on_wire.cell_id;
          samples_if.cell_voltage <= on_wire.volt;
          samples_if.scan_last <= on_wire.last;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    int stall_pct;
    stall_pct = (n_results < IdleSwap) ? 50 : (n_results < IdleOff) ? 37 : 0;
    if (!rst && results_if.valid && results_if.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected transaction: status %0d cell %0d safe %0d",
                             results_if.fault_status, results_if.fault_cell,
                             results_if.scan_safe));
      end else begin
        want = expected_q.pop_front();
        if (results_if.fault_status !== want.status)
          flag_error($sformatf("result %0d fault_status: expected %0d got %0d",
                               n_results, want.status, results_if.fault_status));
        if (results_if.fault_cell !== want.cell_id)
          flag_error($sformatf("result %0d fault_cell: expected %0d got %0d",
                               n_results, want.cell_id, results_if.fault_cell));
        if (results_if.scan_safe !== want.safe)
          flag_error($sformatf("result %0d scan_safe: expected %0d got %0d",
                               n_results, want.safe, results_if.scan_safe));
        if (want.status == cvfq_pkg::StOver) n_over_trips++;
        if (want.status == cvfq_pkg::StUnder) n_under_trips++;
        if (want.status == cvfq_pkg::StIgnored) n_ignored++;
        if (want.safe) n_safe++;
      end
    end
    results_if.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("cell_voltage_fault_qualifier_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int target;
    trip_plan_e trip_mode;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.cell_index = '0;
    samples_if.cell_voltage = '0;
    samples_if.scan_last = 1'b0;
    results_if.ready = 1'b0;
    pack = '0;
    pack.over_lim = cvfq_pkg::OverLimitReset;
    pack.under_lim = cvfq_pkg::UnderLimitReset;
    pack.bad_lim = cvfq_pkg::BadLimitReset;
    plan = pack;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset limits: threshold edges, field extremes, dropped cells
    queue_reading(0, 42000, 0);
    queue_reading(0, 41999, 0);
    queue_reading(29, 27500, 0);
    queue_reading(29, 27501, 1);
    queue_reading(1, 0, 0);
    queue_reading(2, VoltMax, 0);
    queue_reading(3, 42000, 0);
    queue_reading(3, 27500, 0);
    queue_reading(3, 42001, 0);
    queue_reading(3, 30000, 1);
    queue_reading(31, VoltMax, 1);
    queue_reading(30, 0, 0);
    queue_reading(16, 16'h5555, 1);
    queue_reading(15, 16'hAAAA, 0);
    queue_reading(8, 27501, 0);
    queue_reading(4, 41999, 1);
    settle();
    // zero bad-sample limit; only dropped cells so the latch stays clear
    write_reg(cvfq_pkg::RegBadLimit, 0);
    queue_reading(30, VoltMax, 1);
    queue_reading(31, 0, 0);

    set_limits(VoltMax, 0, cvfq_pkg::CountMax);
    run_scans(3, 30, 30, 15);
    set_limits(0, 0, cvfq_pkg::CountMax);
    run_scans(2, 30, 30, 15);
    set_limits(VoltMax, VoltMax, cvfq_pkg::CountMax);
    run_scans(2, 30, 30, 15);
    set_limits(1000, 999, 200);
    run_scans(2, 40, 40, 15);
    set_limits(1001, 999, $urandom_range(4, 1));
    run_scans(3, 30, 30, 15);
    for (int ph = 0; ph < 8; ph++) begin
      target = $urandom_range(50000);
      set_limits(target + $urandom_range(8000, 2), target,
                 ($urandom_range(3) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1));
      run_scans(3 + $urandom_range(1), $urandom_range(45, 10), $urandom_range(45, 10),
                $urandom_range(25));
    end

    // the single trip of the run, then transactions after the latch
    trip_mode = trip_plan_e'($urandom_range(3));
    target = $urandom_range(cvfq_pkg::NumCells - 1);
    case (trip_mode)
      TRIP_ZERO_LIMIT: set_limits(40000, 30000, 0);
      TRIP_BOTH_HIGH:  set_limits(40000, 30000, cvfq_pkg::CountMax);
      default:         set_limits(40000, 30000, $urandom_range(6, 2));
    endcase
    queue_reading(target, 35000, 0);
    if (trip_mode == TRIP_BOTH_HIGH) begin
      // both counts past the lowered limit: over must win on an under sample
      repeat (3) queue_reading(target, draw_voltage(BAND_LOW), 0);
      repeat (3) queue_reading(target, draw_voltage(BAND_HIGH), 0);
      settle();
      write_reg(cvfq_pkg::RegBadLimit, 2);
      queue_reading(target, draw_voltage(BAND_LOW), 1);
    end
    while (!plan.tripped) begin
      for (int c = 0; c < cvfq_pkg::NumCells; c++) begin
        if (c == target)
          queue_reading(c, draw_voltage((trip_mode == TRIP_OVER_RUN) ? BAND_HIGH : BAND_LOW),
                        c == cvfq_pkg::NumCells - 1);
        else
          queue_steered(c, random_band(20, 20), c == cvfq_pkg::NumCells - 1);
      end
    end
    repeat (40) queue_reading($urandom_range(CellMax), $urandom_range(VoltMax),
                              1'($urandom_range(1)));

    settle();
    repeat (4) @(posedge clk);
    $display("%0d samples checked over %0d register writes; trip by %s",
             n_results, n_cfg_writes, trip_mode.name());
    $display("%0d over trips, %0d under trips, %0d ignored after the latch, %0d safe scan ends",
             n_over_trips, n_under_trips, n_ignored, n_safe);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("cell_voltage_fault_qualifier_unit verification clean");
    end else begin
      $display("cell_voltage_fault_qualifier_unit verification failed");
    end
    $finish;
  end

endmodule
